// ===== hdl/spi_pkg.sv =====
// Types and constants shared by the segment pair intersection block.
// No dependencies; compile before the modules in hdl/.
package spi_pkg;

   localparam int FRAC_BITS   = 30;
   localparam int OUT_W       = 32;
   localparam int IDX_W       = 10;
   localparam int LANES       = 3;
   // one result bit per step, plus the bit for the value 2^30 itself
   localparam int NSTEP       = FRAC_BITS + 1;
   localparam int SCALE_SHIFT = 2 * FRAC_BITS + 2;

   localparam logic signed [OUT_W-1:0] UNIT_POS = 32'sh4000_0000;
   localparam logic signed [OUT_W-1:0] UNIT_NEG = -32'sh4000_0000;

   typedef logic [IDX_W-1:0] index_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] point_x;
      logic signed [OUT_W-1:0] point_y;
      logic signed [OUT_W-1:0] point_w;
      index_type               pair_first;
      index_type               pair_second;
      logic                    degenerate;
   } rsp_type;

endpackage

// ===== hdl/segment_pair_intersection.sv =====
// Segment pair intersection: homogeneous line equations, intersection and
// exact round-to-nearest unit normalization in Q2.30. Uses spi_pkg.
//
// Usage
//   Request channel (req_*): one pair of segments with their two indices.
//   A request is taken at a clock edge with req_valid high and req_stall low.
//   Response channel (rsp_*): the unit homogeneous point, the echoed indices
//   and the degenerate flag, taken with rsp_valid high and rsp_stall low.
//   csr_write_enable writes csr_write_data into the crossing suppression bit;
//   a suppressed pair produces no response at all.
//   Throughput is one request per cycle while req_stall is low. A request passes
//   six setup stages (line equations, intersection, squares, norm) and 32
//   stages of the normalizer, the first of which forms the initial slack while
//   each of the other 31 settles one result bit for all three components side
//   by side.
//   Behind the last stage sit an output register and a one-entry skid
//   register. When the receiver stalls, the skid register fills and
//   req_stall rises, freezing the whole pipeline until the response is taken;
//   nothing is lost or repeated.
//   Reset empties the pipeline and sets crossing suppression on.
module segment_pair_intersection #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic                              csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [COORD_BITS-1:0]             req_first_start_x,
   input  logic [COORD_BITS-1:0]             req_first_start_y,
   input  logic [COORD_BITS-1:0]             req_first_end_x,
   input  logic [COORD_BITS-1:0]             req_first_end_y,
   input  logic [COORD_BITS-1:0]             req_second_start_x,
   input  logic [COORD_BITS-1:0]             req_second_start_y,
   input  logic [COORD_BITS-1:0]             req_second_end_x,
   input  logic [COORD_BITS-1:0]             req_second_end_y,
   input  spi_pkg::index_type                req_first_index,
   input  spi_pkg::index_type                req_second_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [spi_pkg::OUT_W-1:0]  rsp_point_x,
   output logic signed [spi_pkg::OUT_W-1:0]  rsp_point_y,
   output logic signed [spi_pkg::OUT_W-1:0]  rsp_point_w,
   output spi_pkg::index_type                rsp_pair_first,
   output spi_pkg::index_type                rsp_pair_second,
   output logic                              rsp_degenerate
);

   localparam int CW  = COORD_BITS;
   localparam int PW  = 2 * COORD_BITS;
   localparam int XW  = 2 * COORD_BITS + 1;
   localparam int EW  = COORD_BITS + 1;
   localparam int QW  = 2 * COORD_BITS + 3;
   localparam int VW  = 3 * COORD_BITS + 3;
   localparam int AW  = 3 * COORD_BITS + 1;
   localparam int LB  = (AW + 1) / 2;
   localparam int HB  = AW - LB;
   localparam int SQW = 2 * AW;
   localparam int SW  = 2 * AW + 2;
   localparam int DW  = 2 * AW + 70;
   localparam int RW  = spi_pkg::NSTEP;
   localparam int NS  = spi_pkg::NSTEP;
   localparam int NL  = spi_pkg::LANES;
   localparam int OW  = spi_pkg::OUT_W;

   function automatic logic signed [XW-1:0] cross_f(
      input logic [CW-1:0] px, input logic [CW-1:0] py,
      input logic [CW-1:0] rx, input logic [CW-1:0] ry);
      logic [PW-1:0] m0;
      logic [PW-1:0] m1;
      m0 = px * ry;
      m1 = py * rx;
      return $signed({1'b0, m0}) - $signed({1'b0, m1});
   endfunction

   // ---------------------------------------------------------------- control
   logic suppress_ff;
   logic skid_vld_ff, skid_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic adv;

   assign adv       = ~skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         suppress_ff <= 1'b1;
      end else if (csr_write_enable) begin
         suppress_ff <= csr_write_data;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic                      s1_vld_ff;
   logic signed [EW-1:0]      s1_e0_ff, s1_e1_ff, s1_f0_ff, s1_f1_ff;
   logic signed [XW-1:0]      s1_e2_ff, s1_f2_ff;
   logic signed [XW-1:0]      s1_c11_ff, s1_c12_ff, s1_c21_ff, s1_c22_ff;
   spi_pkg::index_type        s1_first_ff, s1_second_ff;

   // ---------------------------------------------------------------- stage 2
   logic                      s2_vld_ff;
   logic signed [VW-1:0]      s2_v_ff [NL];
   logic signed [VW-1:0]      s2_v_in [NL];
   logic signed [QW-1:0]      s2_q_ff, s2_num_ff;
   logic signed [EW-1:0]      s2_e0_ff, s2_e1_ff;
   spi_pkg::index_type        s2_first_ff, s2_second_ff;
   logic signed [VW-2:0]      p_a, p_b, p_c, p_d;
   logic signed [2*EW-1:0]    p_e, p_f;

   // ---------------------------------------------------------------- stage 3
   logic                      s3_vld_ff, s3_vld_in;
   logic [AW-1:0]             s3_mag_ff [NL];
   logic [AW-1:0]             s3_mag_in [NL];
   logic [NL-1:0]             s3_neg_ff, s3_neg_in;
   logic                      s3_deg_ff, s3_deg_in;
   spi_pkg::index_type        s3_first_ff, s3_second_ff;
   logic signed [VW-1:0]      sel_v [NL];
   logic signed [VW-1:0]      abs_v [NL];
   logic                      v_zero, drop;

   // ---------------------------------------------------------------- stage 4
   logic                      s4_vld_ff;
   logic [2*HB-1:0]           s4_hh_ff [NL];
   logic [HB+LB-1:0]          s4_hl_ff [NL];
   logic [2*LB-1:0]           s4_ll_ff [NL];
   logic [NL-1:0]             s4_neg_ff;
   logic                      s4_deg_ff;
   spi_pkg::index_type        s4_first_ff, s4_second_ff;

   // ---------------------------------------------------------------- stage 5
   logic                      s5_vld_ff;
   logic [SQW-1:0]            s5_sq_ff [NL];
   logic [NL-1:0]             s5_neg_ff;
   logic                      s5_deg_ff;
   spi_pkg::index_type        s5_first_ff, s5_second_ff;

   // ---------------------------------------------------------------- stage 6
   logic                      s6_vld_ff;
   logic [SQW-1:0]            s6_sq_ff [NL];
   logic [SW-1:0]             s6_s_ff;
   logic [NL-1:0]             s6_neg_ff;
   logic                      s6_deg_ff;
   spi_pkg::index_type        s6_first_ff, s6_second_ff;

   // ------------------------------------------------------ normalizer stages
   logic [NS:0]               st_vld_ff;
   wire  [NS:0]               st_vld_in;
   logic [SW-1:0]             st_s_ff [NS+1];
   wire  [SW-1:0]             st_s_in [NS+1];
   logic signed [DW-1:0]      st_d_ff [NS+1][NL];
   wire  signed [DW-1:0]      st_d_in [NS+1][NL];
   logic [DW-1:0]             st_h_ff [NS+1][NL];
   wire  [DW-1:0]             st_h_in [NS+1][NL];
   logic [RW-1:0]             st_r_ff [NS+1][NL];
   wire  [RW-1:0]             st_r_in [NS+1][NL];
   logic [NL-1:0]             st_neg_ff [NS+1];
   wire  [NL-1:0]             st_neg_in [NS+1];
   logic [NS:0]               st_deg_ff;
   wire  [NS:0]               st_deg_in;
   spi_pkg::index_type        st_first_ff [NS+1];
   wire  spi_pkg::index_type  st_first_in [NS+1];
   spi_pkg::index_type        st_second_ff [NS+1];
   wire  spi_pkg::index_type  st_second_in [NS+1];

   // -------------------------------------------------------------- datapath
   always_comb begin
      p_a = s1_e1_ff * s1_f2_ff;
      p_b = s1_e2_ff * s1_f1_ff;
      p_c = s1_e2_ff * s1_f0_ff;
      p_d = s1_e0_ff * s1_f2_ff;
      p_e = s1_e0_ff * s1_f1_ff;
      p_f = s1_e1_ff * s1_f0_ff;
      s2_v_in[0] = VW'(p_a) - VW'(p_b);
      s2_v_in[1] = VW'(p_c) - VW'(p_d);
      s2_v_in[2] = VW'(p_e) - VW'(p_f);
   end

   always_comb begin
      v_zero = (s2_v_ff[0] == '0) && (s2_v_ff[1] == '0) && (s2_v_ff[2] == '0);
      // same line or a degenerate segment: fall back to the first line's direction
      if (v_zero) begin
         sel_v[0] = VW'(0) - VW'(s2_e1_ff);
         sel_v[1] = VW'(s2_e0_ff);
         sel_v[2] = '0;
      end else begin
         sel_v[0] = s2_v_ff[0];
         sel_v[1] = s2_v_ff[1];
         sel_v[2] = s2_v_ff[2];
      end
      for (int l = 0; l < NL; l++) begin
         s3_neg_in[l] = sel_v[l][VW-1];
         abs_v[l]     = sel_v[l][VW-1] ? (VW'(0) - sel_v[l]) : sel_v[l];
         s3_mag_in[l] = abs_v[l][AW-1:0];
      end
      s3_deg_in = v_zero && (s2_e0_ff == '0) && (s2_e1_ff == '0);
      // drop when num/q lies strictly between 0 and 1
      drop = suppress_ff &&
             (((s2_q_ff > 0) && (s2_num_ff > 0) && (s2_num_ff < s2_q_ff)) ||
              ((s2_q_ff < 0) && (s2_num_ff < 0) && (s2_num_ff > s2_q_ff)));
      s3_vld_in = s2_vld_ff && !drop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         st_vld_ff <= '0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         st_vld_ff <= st_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_e0_ff     <= $signed({1'b0, req_first_start_y}) - $signed({1'b0, req_first_end_y});
         s1_e1_ff     <= $signed({1'b0, req_first_end_x}) - $signed({1'b0, req_first_start_x});
         s1_e2_ff     <= cross_f(req_first_start_x, req_first_start_y,
                                 req_first_end_x, req_first_end_y);
         s1_f0_ff     <= $signed({1'b0, req_second_start_y}) - $signed({1'b0, req_second_end_y});
         s1_f1_ff     <= $signed({1'b0, req_second_end_x}) - $signed({1'b0, req_second_start_x});
         s1_f2_ff     <= cross_f(req_second_start_x, req_second_start_y,
                                 req_second_end_x, req_second_end_y);
         s1_c11_ff    <= cross_f(req_first_start_x, req_first_start_y,
                                 req_second_start_x, req_second_start_y);
         s1_c12_ff    <= cross_f(req_first_start_x, req_first_start_y,
                                 req_second_end_x, req_second_end_y);
         s1_c21_ff    <= cross_f(req_first_end_x, req_first_end_y,
                                 req_second_start_x, req_second_start_y);
         s1_c22_ff    <= cross_f(req_first_end_x, req_first_end_y,
                                 req_second_end_x, req_second_end_y);
         s1_first_ff  <= req_first_index;
         s1_second_ff <= req_second_index;

         for (int l = 0; l < NL; l++) begin
            s2_v_ff[l] <= s2_v_in[l];
         end
         s2_q_ff      <= QW'(s1_c11_ff) - QW'(s1_c12_ff) - QW'(s1_c21_ff) + QW'(s1_c22_ff);
         s2_num_ff    <= QW'(s1_c11_ff) - QW'(s1_c12_ff) + QW'(s1_f2_ff);
         s2_e0_ff     <= s1_e0_ff;
         s2_e1_ff     <= s1_e1_ff;
         s2_first_ff  <= s1_first_ff;
         s2_second_ff <= s1_second_ff;

         for (int l = 0; l < NL; l++) begin
            s3_mag_ff[l] <= s3_mag_in[l];
         end
         s3_neg_ff    <= s3_neg_in;
         s3_deg_ff    <= s3_deg_in;
         s3_first_ff  <= s2_first_ff;
         s3_second_ff <= s2_second_ff;

         // squares as three partial products
         for (int l = 0; l < NL; l++) begin
            s4_hh_ff[l] <= s3_mag_ff[l][AW-1:LB] * s3_mag_ff[l][AW-1:LB];
            s4_hl_ff[l] <= s3_mag_ff[l][AW-1:LB] * s3_mag_ff[l][LB-1:0];
            s4_ll_ff[l] <= s3_mag_ff[l][LB-1:0] * s3_mag_ff[l][LB-1:0];
         end
         s4_neg_ff    <= s3_neg_ff;
         s4_deg_ff    <= s3_deg_ff;
         s4_first_ff  <= s3_first_ff;
         s4_second_ff <= s3_second_ff;

         for (int l = 0; l < NL; l++) begin
            s5_sq_ff[l] <= (SQW'(s4_hh_ff[l]) << (2 * LB)) +
                           (SQW'(s4_hl_ff[l]) << (LB + 1)) + SQW'(s4_ll_ff[l]);
         end
         s5_neg_ff    <= s4_neg_ff;
         s5_deg_ff    <= s4_deg_ff;
         s5_first_ff  <= s4_first_ff;
         s5_second_ff <= s4_second_ff;

         for (int l = 0; l < NL; l++) begin
            s6_sq_ff[l] <= s5_sq_ff[l];
         end
         s6_s_ff      <= SW'(s5_sq_ff[0]) + SW'(s5_sq_ff[1]) + SW'(s5_sq_ff[2]);
         s6_neg_ff    <= s5_neg_ff;
         s6_deg_ff    <= s5_deg_ff;
         s6_first_ff  <= s5_first_ff;
         s6_second_ff <= s5_second_ff;

         for (int j = 0; j <= NS; j++) begin
            st_s_ff[j]      <= st_s_in[j];
            st_neg_ff[j]    <= st_neg_in[j];
            st_deg_ff[j]    <= st_deg_in[j];
            st_first_ff[j]  <= st_first_in[j];
            st_second_ff[j] <= st_second_in[j];
            for (int l = 0; l < NL; l++) begin
               st_d_ff[j][l] <= st_d_in[j][l];
               st_h_ff[j][l] <= st_h_in[j][l];
               st_r_ff[j][l] <= st_r_in[j][l];
            end
         end
      end
   end

   // Normalizer: find the largest r with (2r-1)^2 * s <= 4 * a^2 * 2^60.
   // D holds the remaining slack, H holds r * s.
   assign st_vld_in[0]    = s6_vld_ff;
   assign st_s_in[0]      = s6_s_ff;
   assign st_neg_in[0]    = s6_neg_ff;
   assign st_deg_in[0]    = s6_deg_ff;
   assign st_first_in[0]  = s6_first_ff;
   assign st_second_in[0] = s6_second_ff;

   for (genvar l = 0; l < NL; l++) begin : g_init
      assign st_d_in[0][l] = (DW'(s6_sq_ff[l]) << spi_pkg::SCALE_SHIFT) - DW'(s6_s_ff);
      assign st_h_in[0][l] = '0;
      assign st_r_in[0][l] = '0;
   end

   for (genvar j = 0; j < NS; j++) begin : g_step
      localparam int K = NS - 1 - j;

      assign st_vld_in[j+1]    = st_vld_ff[j];
      assign st_s_in[j+1]      = st_s_ff[j];
      assign st_neg_in[j+1]    = st_neg_ff[j];
      assign st_deg_in[j+1]    = st_deg_ff[j];
      assign st_first_in[j+1]  = st_first_ff[j];
      assign st_second_in[j+1] = st_second_ff[j];

      for (genvar l = 0; l < NL; l++) begin : g_lane
         logic [DW-1:0] inc;
         logic          fit;

         assign inc = (st_h_ff[j][l] << (K + 3)) + (DW'(st_s_ff[j]) << (2 * K + 2)) -
                      (DW'(st_s_ff[j]) << (K + 2));
         assign fit = !st_d_ff[j][l][DW-1] && ($unsigned(st_d_ff[j][l]) >= inc);

         assign st_d_in[j+1][l] = fit ? (st_d_ff[j][l] - $signed(inc)) : st_d_ff[j][l];
         assign st_h_in[j+1][l] = fit ? (st_h_ff[j][l] + (DW'(st_s_ff[j]) << K))
                                      : st_h_ff[j][l];
         assign st_r_in[j+1][l] = fit ? (st_r_ff[j][l] | (RW'(1) << K)) : st_r_ff[j][l];
      end
   end

   // ---------------------------------------------------------------- output
   spi_pkg::rsp_type pipe_rsp;
   spi_pkg::rsp_type rsp_ff, rsp_in;
   spi_pkg::rsp_type skid_ff;
   logic signed [OW-1:0] pt [NL];
   logic take, rsp_free, move, load_skid, load_pipe, skid_load;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         if (st_deg_ff[NS]) begin
            pt[l] = '0;
         end else if (st_neg_ff[NS][l]) begin
            pt[l] = OW'(0) - OW'(st_r_ff[NS][l]);
         end else begin
            pt[l] = OW'(st_r_ff[NS][l]);
         end
      end
      pipe_rsp.point_x     = pt[0];
      pipe_rsp.point_y     = pt[1];
      pipe_rsp.point_w     = pt[2];
      pipe_rsp.pair_first  = st_first_ff[NS];
      pipe_rsp.pair_second = st_second_ff[NS];
      pipe_rsp.degenerate  = st_deg_ff[NS];
   end

   always_comb begin
      take        = rsp_vld_ff && !rsp_stall;
      rsp_free    = !rsp_vld_ff || take;
      move        = adv && st_vld_ff[NS];
      load_skid   = skid_vld_ff && rsp_free;
      load_pipe   = !skid_vld_ff && move && rsp_free;
      skid_load   = move && !rsp_free;
      rsp_vld_in  = load_skid || load_pipe || (rsp_vld_ff && !take);
      skid_vld_in = skid_load || (skid_vld_ff && !rsp_free);
      rsp_in      = load_skid ? skid_ff : pipe_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_skid || load_pipe) begin
         rsp_ff <= rsp_in;
      end
      if (skid_load) begin
         skid_ff <= pipe_rsp;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_point_x     = rsp_ff.point_x;
   assign rsp_point_y     = rsp_ff.point_y;
   assign rsp_point_w     = rsp_ff.point_w;
   assign rsp_pair_first  = rsp_ff.pair_first;
   assign rsp_pair_second = rsp_ff.pair_second;
   assign rsp_degenerate  = rsp_ff.degenerate;

   // ------------------------------------------------------------ assertions
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid register holds a request while the output is empty");

   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.degenerate) |->
         (rsp_ff.point_x == '0 && rsp_ff.point_y == '0 && rsp_ff.point_w == '0))
      else $error("degenerate response carries a nonzero point");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |->
         (rsp_ff.point_x <= spi_pkg::UNIT_POS && rsp_ff.point_x >= spi_pkg::UNIT_NEG &&
          rsp_ff.point_y <= spi_pkg::UNIT_POS && rsp_ff.point_y >= spi_pkg::UNIT_NEG &&
          rsp_ff.point_w <= spi_pkg::UNIT_POS && rsp_ff.point_w >= spi_pkg::UNIT_NEG))
      else $error("normalized component out of unit range");

   a_frozen_when_full : assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && $past(skid_vld_ff) && !$past(reset)) |-> $stable(st_vld_ff))
      else $error("pipeline advanced while the skid register was full");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for segment_pair_intersection.
// Drives random and directed segment pairs, predicts each unit point exactly
// and checks responses in order. Depends on hdl/spi_pkg.sv and the block.
`timescale 1ns / 100ps

class intersection_scoreboard;
   spi_pkg::rsp_type pending_points[$];
   int               fail_count = 0;
   int               checked_count = 0;
   int               dropped_count = 0;
   int               degenerate_count = 0;
   bit               suppress_on = 1;

   // 2D cross product of two points
   static function longint cross_pt(longint px, longint py, longint rx, longint ry);
      return px * ry - py * rx;
   endfunction

   // round(a * 2^30 / sqrt(s)), ties away from zero, by bisection on
   // (2r-1)^2 * s <= a^2 * 2^62
   static function longint unit_part(longint a, logic [255:0] s);
      logic [255:0] bound;
      logic [255:0] lhs;
      longint lo, hi, mid;
      logic [63:0] odd;
      if (a == 0) return 0;
      bound = 256'(a) * 256'(a);
      bound = bound << 62;
      lhs = s;
      if (lhs > bound) return 0;
      lo = 1;
      hi = 64'd1 << 30;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 2 * mid - 1;
         lhs = 256'(odd) * 256'(odd) * s;
         if (lhs <= bound) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // note an accepted request and queue its expected response, if any
   function void note_request(longint ax1, longint ay1, longint ax2, longint ay2,
                              longint bx1, longint by1, longint bx2, longint by2,
                              spi_pkg::index_type fi, spi_pkg::index_type si);
      longint e0, e1, e2, f0, f1, f2, q, num, c11, c12, c21, c22;
      longint v[3];
      longint mag;
      logic [255:0] norm_sq;
      spi_pkg::rsp_type point;
      e0 = ay1 - ay2;
      e1 = ax2 - ax1;
      e2 = cross_pt(ax1, ay1, ax2, ay2);
      f0 = by1 - by2;
      f1 = bx2 - bx1;
      f2 = cross_pt(bx1, by1, bx2, by2);
      v[0] = e1 * f2 - e2 * f1;
      v[1] = e2 * f0 - e0 * f2;
      v[2] = e0 * f1 - e1 * f0;
      if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
         v[0] = -e1;
         v[1] = e0;
         v[2] = 0;
      end
      if (suppress_on) begin
         c11 = cross_pt(ax1, ay1, bx1, by1);
         c12 = cross_pt(ax1, ay1, bx2, by2);
         c21 = cross_pt(ax2, ay2, bx1, by1);
         c22 = cross_pt(ax2, ay2, bx2, by2);
         q = c11 - c12 - c21 + c22;
         num = c11 - c12 + f2;
         if ((q > 0 && num > 0 && num < q) || (q < 0 && num < 0 && num > q)) begin
            dropped_count++;
            return;
         end
      end
      point = '0;
      point.pair_first = fi;
      point.pair_second = si;
      if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
         point.degenerate = 1'b1;
         degenerate_count++;
      end else begin
         norm_sq = '0;
         for (int i = 0; i < 3; i++) begin
            mag = v[i] < 0 ? -v[i] : v[i];
            norm_sq += 256'(mag) * 256'(mag);
         end
         for (int i = 0; i < 3; i++) begin
            mag = unit_part(v[i] < 0 ? -v[i] : v[i], norm_sq);
            if (v[i] < 0) mag = -mag;
            if (i == 0) point.point_x = mag[31:0];
            else if (i == 1) point.point_y = mag[31:0];
            else point.point_w = mag[31:0];
         end
      end
      pending_points.insert(pending_points.size(), point);
   endfunction

   function void check_response(spi_pkg::rsp_type got);
      spi_pkg::rsp_type want;
      if (pending_points.size() == 0) begin
         $error("response with nothing expected: x=%0d y=%0d w=%0d",
                got.point_x, got.point_y, got.point_w);
         fail_count++;
         return;
      end
      want = pending_points.pop_front();
      checked_count++;
      if (got.point_x !== want.point_x) begin
         $error("point_x expected %0d got %0d", want.point_x, got.point_x);
         fail_count++;
      end
      if (got.point_y !== want.point_y) begin
         $error("point_y expected %0d got %0d", want.point_y, got.point_y);
         fail_count++;
      end
      if (got.point_w !== want.point_w) begin
         $error("point_w expected %0d got %0d", want.point_w, got.point_w);
         fail_count++;
      end
      if (got.pair_first !== want.pair_first) begin
         $error("pair_first expected %0d got %0d", want.pair_first, got.pair_first);
         fail_count++;
      end
      if (got.pair_second !== want.pair_second) begin
         $error("pair_second expected %0d got %0d", want.pair_second, got.pair_second);
         fail_count++;
      end
      if (got.degenerate !== want.degenerate) begin
         $error("degenerate expected %0d got %0d", want.degenerate, got.degenerate);
         fail_count++;
      end
   endfunction
endclass

module tb;

   localparam int PIPE_DEPTH = 40;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;
   logic req_valid;
   logic req_stall;
   logic [11:0] req_first_start_x, req_first_start_y, req_first_end_x, req_first_end_y;
   logic [11:0] req_second_start_x, req_second_start_y;
   logic [11:0] req_second_end_x, req_second_end_y;
   spi_pkg::index_type req_first_index, req_second_index;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [spi_pkg::OUT_W-1:0] rsp_point_x, rsp_point_y, rsp_point_w;
   spi_pkg::index_type rsp_pair_first, rsp_pair_second;
   logic rsp_degenerate;

   intersection_scoreboard board;
   bit sender_busy_free = 0;
   bit receiver_busy_free = 0;
   int request_count = 0;

   segment_pair_intersection #(.COORD_BITS(12)) dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_start_x(req_first_start_x), .req_first_start_y(req_first_start_y),
      .req_first_end_x(req_first_end_x), .req_first_end_y(req_first_end_y),
      .req_second_start_x(req_second_start_x), .req_second_start_y(req_second_start_y),
      .req_second_end_x(req_second_end_x), .req_second_end_y(req_second_end_y),
      .req_first_index(req_first_index), .req_second_index(req_second_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_w(rsp_point_w),
      .rsp_pair_first(rsp_pair_first), .rsp_pair_second(rsp_pair_second),
      .rsp_degenerate(rsp_degenerate)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: random stalls, none while receiver_busy_free is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.check_response({rsp_point_x, rsp_point_y, rsp_point_w,
                                  rsp_pair_first, rsp_pair_second, rsp_degenerate});
         rsp_stall <= !receiver_busy_free && ($urandom_range(99) < 13);
      end
   end

   task automatic send_pair(logic [11:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2,
                            spi_pkg::index_type fi, spi_pkg::index_type si);
      while (!sender_busy_free && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_start_x <= ax1;
      req_first_start_y <= ay1;
      req_first_end_x <= ax2;
      req_first_end_y <= ay2;
      req_second_start_x <= bx1;
      req_second_start_y <= by1;
      req_second_end_x <= bx2;
      req_second_end_y <= by2;
      req_first_index <= fi;
      req_second_index <= si;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(longint'(ax1), longint'(ay1), longint'(ax2), longint'(ay2),
                         longint'(bx1), longint'(by1), longint'(bx2), longint'(by2),
                         fi, si);
      request_count++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (board.pending_points.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   task automatic write_suppress(bit value);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.suppress_on = value;
   endtask

   // coordinate that favors small segments near the extremes now and then
   function automatic logic [11:0] pick_coord();
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'hFFF;
         2: return 12'($urandom_range(15));
         default: return 12'($urandom);
      endcase
   endfunction

   task automatic send_random_pair();
      logic [11:0] c[8];
      int shape;
      for (int i = 0; i < 8; i++) c[i] = pick_coord();
      shape = $urandom_range(19);
      if (shape == 0) begin
         c[2] = c[0];
         c[3] = c[1];
      end else if (shape == 1) begin
         // second segment on the first one's line
         c[4] = c[0];
         c[5] = c[1];
         c[6] = c[2];
         c[7] = c[3];
      end else if (shape == 2) begin
         c[6] = c[4];
         c[7] = c[5];
      end
      send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                spi_pkg::index_type'($urandom), spi_pkg::index_type'($urandom));
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_valid = 1'b0;
      {req_first_start_x, req_first_start_y, req_first_end_x, req_first_end_y} = '0;
      {req_second_start_x, req_second_start_y, req_second_end_x, req_second_end_y} = '0;
      req_first_index = '0;
      req_second_index = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: crossing and non-crossing pairs, some degenerate, with suppression on (reset value), then off
      for (int pass = 0; pass < 2; pass++) begin
         send_pair(12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'd0, 12'hFFF, 12'hFFF, 12'd0,
                   10'd0, 10'h3FF);
         send_pair(12'd0, 12'd0, 12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF,
                   10'h3FF, 10'd0);
         send_pair(12'd5, 12'd5, 12'd5, 12'd5, 12'd1, 12'd2, 12'd3, 12'd4, 10'd7, 10'd3);
         send_pair(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                   12'hFFF, 12'hFFF, 10'h3FF, 10'h3FF);
         send_pair(12'd0, 12'd0, 12'd10, 12'd10, 12'd20, 12'd20, 12'd30, 12'd30,
                   10'd12, 10'd11);
         send_pair(12'd0, 12'd0, 12'd10, 12'd0, 12'd5, 12'd0, 12'd5, 12'd10, 10'd1, 10'd2);
         send_pair(12'd0, 12'd0, 12'd10, 12'd0, 12'd5, 12'd20, 12'd5, 12'd10, 10'd2, 10'd1);
         send_pair(12'd0, 12'd0, 12'd10, 12'd0, 12'd10, 12'd0, 12'd10, 12'd10, 10'd3, 10'd4);
         send_pair(12'd0, 12'd0, 12'd10, 12'd0, 12'd0, 12'd0, 12'd0, 12'd10, 10'd4, 10'd3);
         send_pair(12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'd1, 12'd1, 12'hFFE, 12'hFFE,
                   10'h2AA, 10'h155);
         send_pair(12'd0, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'd0,
                   10'h155, 10'h2AA);
         write_suppress(pass == 0 ? 1'b0 : 1'b1);
      end

      for (int phase = 0; phase < 4; phase++) begin
         sender_busy_free = (phase == 2);
         receiver_busy_free = (phase == 2);
         for (int n = 0; n < 300; n++) begin
            send_random_pair();
            // pause until the pipeline is empty once per phase
            if (n == 150) drain_pipeline();
         end
         write_suppress(phase[0]);
      end
      sender_busy_free = 0;
      receiver_busy_free = 0;

      drain_pipeline();
      $display("covered %0d requests: %0d responses checked, %0d suppressed, %0d degenerate",
               request_count, board.checked_count, board.dropped_count,
               board.degenerate_count);
      if (board.fail_count == 0 && board.pending_points.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/spi_pkg.sv
hdl/segment_pair_intersection.sv
sim/tb.sv
